FILE: rtl/hfw_pkg.sv
// ----------------------------------------------------------------------------
// hfw_pkg: shared types and constants of the Huffman tree-walk decoder
// Node table geometry, entry layout and the request structs between the
// walk sequencer and the node table.
// ----------------------------------------------------------------------------
package hfw_pkg;

	localparam int NODES  = 512;
	localparam int IDX_W  = 9;
	localparam int SYM_W  = 8;
	localparam int BYTE_W = 8;
	localparam int NBITS_W = 4;
	localparam int ADDR_W = $clog2(NODES);

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	typedef struct packed {
		logic             leaf;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] symbol;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		entry_t           ent;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} rd_req_t;

	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} push_t;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < NODES;
	endfunction

endpackage

FILE: rtl/hfw_node_mem.sv
// ----------------------------------------------------------------------------
// hfw_node_mem: code tree node table
// One write port and one registered read port. A read of a slot beyond the
// table returns an all-zero entry. A copy of the root's children is kept in
// registers so the walk can restart at the root without a table read.
// ----------------------------------------------------------------------------
module hfw_node_mem (
	input  logic                    clk,
	input  hfw_pkg::wr_req_t        wr,
	input  hfw_pkg::rd_req_t        rd,
	output hfw_pkg::entry_t         ent,
	output logic [hfw_pkg::IDX_W-1:0] root_left,
	output logic [hfw_pkg::IDX_W-1:0] root_right
);

	hfw_pkg::entry_t mem_q [hfw_pkg::NODES];
	hfw_pkg::entry_t rd_data_q;
	logic            rd_oor_q;
	logic [hfw_pkg::IDX_W-1:0] root_left_q;
	logic [hfw_pkg::IDX_W-1:0] root_right_q;

	always_ff @(posedge clk) begin
		if (wr.en && hfw_pkg::in_range(wr.idx)) begin
			mem_q[hfw_pkg::ADDR_W'(wr.idx)] <= wr.ent;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == '0) begin
			root_left_q  <= wr.ent.left;
			root_right_q <= wr.ent.right;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem_q[hfw_pkg::ADDR_W'(rd.idx)];
			rd_oor_q  <= !hfw_pkg::in_range(rd.idx);
		end
	end

	assign ent        = rd_oor_q ? '0 : rd_data_q;
	assign root_left  = root_left_q;
	assign root_right = root_right_q;

endmodule

FILE: rtl/hfw_walk_ctl.sv
// ----------------------------------------------------------------------------
// hfw_walk_ctl: tree walk sequencer
// Takes items, writes loaded nodes and steps through the coded bits one
// table read per bit. The newest symbol waits in a holding register until
// the next one, or the end of the word, shows whether it is the last.
// ----------------------------------------------------------------------------
module hfw_walk_ctl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [hfw_pkg::IDX_W-1:0]   node_index,
	input  logic                        node_leaf,
	input  logic [hfw_pkg::IDX_W-1:0]   left_child,
	input  logic [hfw_pkg::IDX_W-1:0]   right_child,
	input  logic [hfw_pkg::SYM_W-1:0]   node_symbol,
	input  logic [hfw_pkg::BYTE_W-1:0]  data_byte,
	input  logic [hfw_pkg::NBITS_W-1:0] bit_count,
	input  hfw_pkg::entry_t             ent,
	input  logic [hfw_pkg::IDX_W-1:0]   root_left,
	input  logic [hfw_pkg::IDX_W-1:0]   root_right,
	input  logic                        slot_free,
	output hfw_pkg::wr_req_t            wr,
	output hfw_pkg::rd_req_t            rd,
	output hfw_pkg::push_t              push
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FIRST = 2'd1;
	localparam logic [1:0] S_WALK  = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0]                   state_q, state_d;
	logic [hfw_pkg::IDX_W-1:0]    cur_q, cur_d;
	logic [hfw_pkg::IDX_W-1:0]    next_q, next_d;
	logic [hfw_pkg::BYTE_W-1:0]   byte_q, byte_d;
	logic [hfw_pkg::NBITS_W-1:0]  bits_q, bits_d;
	logic [hfw_pkg::SYM_W-1:0]    pend_q, pend_d;
	logic                         pend_v_q, pend_v_d;

	logic                         accept;
	logic [hfw_pkg::NBITS_W-1:0]  nbits;
	logic                         leaf;
	logic [hfw_pkg::IDX_W-1:0]    kid_left, kid_right, sel_child;

	assign accept   = in_valid && state_q == S_IDLE;
	assign in_stall = state_q != S_IDLE;
	assign nbits    = (bit_count == '0 || bit_count > hfw_pkg::NBITS_W'(hfw_pkg::BYTE_W))
		? hfw_pkg::NBITS_W'(hfw_pkg::BYTE_W) : bit_count;

	// After a leaf the walk restarts at the root, whose children sit in registers.
	assign leaf      = state_q == S_WALK && ent.leaf;
	assign kid_left  = leaf ? root_left  : ent.left;
	assign kid_right = leaf ? root_right : ent.right;
	assign sel_child = byte_q[hfw_pkg::BYTE_W-1] ? kid_right : kid_left;

	always_comb begin
		wr.en         = accept && action == hfw_pkg::ACT_LOAD;
		wr.idx        = node_index;
		wr.ent.leaf   = node_leaf;
		wr.ent.left   = left_child;
		wr.ent.right  = right_child;
		wr.ent.symbol = node_symbol;
	end

	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		next_d      = next_q;
		byte_d      = byte_q;
		bits_d      = bits_q;
		pend_d      = pend_q;
		pend_v_d    = pend_v_q;
		rd.en       = 1'b0;
		rd.idx      = sel_child;
		push.valid  = 1'b0;
		push.symbol = pend_q;
		push.last   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && action == hfw_pkg::ACT_DECODE) begin
					rd.en   = 1'b1;
					rd.idx  = cur_q;
					byte_d  = data_byte;
					bits_d  = nbits;
					state_d = S_FIRST;
				end
			end
			S_FIRST: begin
				rd.en   = 1'b1;
				next_d  = sel_child;
				byte_d  = byte_q << 1;
				bits_d  = bits_q - 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				// A new symbol can only enter while the older one can leave.
				if (!(leaf && pend_v_q && !slot_free)) begin
					if (leaf) begin
						push.valid = pend_v_q;
						pend_d     = ent.symbol;
						pend_v_d   = 1'b1;
						cur_d      = '0;
					end else begin
						cur_d = next_q;
					end
					if (bits_q != '0) begin
						rd.en  = 1'b1;
						next_d = sel_child;
						byte_d = byte_q << 1;
						bits_d = bits_q - 1'b1;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (slot_free) begin
					push.valid = 1'b1;
					push.last  = 1'b1;
					pend_v_d   = 1'b0;
					state_d    = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			pend_v_q <= 1'b0;
			bits_q   <= '0;
		end else begin
			state_q  <= state_d;
			cur_q    <= cur_d;
			pend_v_q <= pend_v_d;
			bits_q   <= bits_d;
		end
	end

	always_ff @(posedge clk) begin
		next_q <= next_d;
		byte_q <= byte_d;
		pend_q <= pend_d;
	end

`ifndef ASSERT_OFF
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> slot_free)
		else $error("symbol pushed while the output register is occupied");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("symbol left pending after the word was finished");

	a_last_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.last |=> state_q == S_IDLE)
		else $error("walk went on after the last symbol of the word");

	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> bits_q <= hfw_pkg::NBITS_W'(hfw_pkg::BYTE_W))
		else $error("bit counter out of range during a walk");
`endif

endmodule

FILE: rtl/huffman_tree_walk_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top: bit-serial Huffman tree-walk decoder
// A load item writes one node of the code tree. For a decode item the
// accepting cycle reads the node where the walk stands, each used coded
// bit then takes one registered table read through the single read port
// of the node table, the node that the last bit reached is then looked at,
// and any last symbol of the word is released. A stalled output can hold
// the walk. Symbols leave through an output register, so one symbol may
// wait there while the walk goes on.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [hfw_pkg::IDX_W-1:0]   node_index,
	input  logic                        node_leaf,
	input  logic [hfw_pkg::IDX_W-1:0]   left_child,
	input  logic [hfw_pkg::IDX_W-1:0]   right_child,
	input  logic [hfw_pkg::SYM_W-1:0]   node_symbol,
	input  logic [hfw_pkg::BYTE_W-1:0]  data_byte,
	input  logic [hfw_pkg::NBITS_W-1:0] bit_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hfw_pkg::SYM_W-1:0]   symbol,
	output logic                        last_of_byte
);

	hfw_pkg::wr_req_t          wr;
	hfw_pkg::rd_req_t          rd;
	hfw_pkg::entry_t           ent;
	hfw_pkg::push_t            push;
	logic [hfw_pkg::IDX_W-1:0] root_left, root_right;
	logic                      slot_free;

	logic                      out_valid_q;
	logic [hfw_pkg::SYM_W-1:0] symbol_q;
	logic                      last_q;

	hfw_node_mem u_mem (
		.clk        (clk),
		.wr         (wr),
		.rd         (rd),
		.ent        (ent),
		.root_left  (root_left),
		.root_right (root_right)
	);

	hfw_walk_ctl u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.node_index  (node_index),
		.node_leaf   (node_leaf),
		.left_child  (left_child),
		.right_child (right_child),
		.node_symbol (node_symbol),
		.data_byte   (data_byte),
		.bit_count   (bit_count),
		.ent         (ent),
		.root_left   (root_left),
		.root_right  (root_right),
		.slot_free   (slot_free),
		.wr          (wr),
		.rd          (rd),
		.push        (push)
	);

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			symbol_q <= push.symbol;
			last_q   <= push.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol       = symbol_q;
	assign last_of_byte = last_q;

endmodule

FILE: tb/huffman_tree_walk_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top_tb: self-checking bench of the tree-walk decoder
// Loads small code trees node by node, feeds coded bytes through the input
// channel with random gaps and output stalls, and compares every decoded symbol
// against a cycle-free software walk of its node table copy or typed-in values.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_top_tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_WORDS   = 280;
	localparam int CALM_WORDS   = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic                      leaf;
		logic [hfw_pkg::IDX_W-1:0] left;
		logic [hfw_pkg::IDX_W-1:0] right;
		logic [hfw_pkg::SYM_W-1:0] symbol;
	} tree_node_t;

	typedef struct packed {
		logic [hfw_pkg::SYM_W-1:0] symbol;
		logic                      last;
	} sym_word_t;

	typedef struct {
		logic                        act;
		logic [hfw_pkg::IDX_W-1:0]   idx;
		logic                        leaf;
		logic [hfw_pkg::IDX_W-1:0]   lc;
		logic [hfw_pkg::IDX_W-1:0]   rc;
		logic [hfw_pkg::SYM_W-1:0]   nsym;
		logic [hfw_pkg::BYTE_W-1:0]  dbyte;
		logic [hfw_pkg::NBITS_W-1:0] nbits;
		logic                        typed;
		int                          n_exp;
		logic [hfw_pkg::SYM_W-1:0]   exp_sym;
	} word_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         action = hfw_pkg::ACT_LOAD;
	logic [hfw_pkg::IDX_W-1:0]    node_index = '0;
	logic                         node_leaf = 1'b0;
	logic [hfw_pkg::IDX_W-1:0]    left_child = '0;
	logic [hfw_pkg::IDX_W-1:0]    right_child = '0;
	logic [hfw_pkg::SYM_W-1:0]    node_symbol = '0;
	logic [hfw_pkg::BYTE_W-1:0]   data_byte = '0;
	logic [hfw_pkg::NBITS_W-1:0]  bit_count = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [hfw_pkg::SYM_W-1:0]    symbol;
	logic                         last_of_byte;

	// Typed-in expectation that travels with the word it belongs to.
	logic                         tag_typed = 1'b0;
	int                           tag_n = 0;
	logic [hfw_pkg::SYM_W-1:0]    tag_sym = '0;

	tree_node_t                   code_tree [hfw_pkg::NODES];
	logic [hfw_pkg::IDX_W-1:0]    walk_at = '0;
	sym_word_t                    walk_out [$];
	sym_word_t                    pending_syms [$];

	bit                           known [hfw_pkg::NODES];
	logic [hfw_pkg::IDX_W-1:0]    known_q [$];
	int                           words_sent = 0;
	int                           words_in = 0;
	int                           calm_at = 32'h7fff_ffff;
	bit                           quiet = 1'b0;
	int                           errors = 0;
	int                           cycles = 0;

	huffman_tree_walk_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.node_index   (node_index),
		.node_leaf    (node_leaf),
		.left_child   (left_child),
		.right_child  (right_child),
		.node_symbol  (node_symbol),
		.data_byte    (data_byte),
		.bit_count    (bit_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.last_of_byte (last_of_byte)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic tree_node_t read_node(input logic [hfw_pkg::IDX_W-1:0] idx);
		if (int'(idx) < hfw_pkg::NODES)
			return code_tree[idx];
		return '0;
	endfunction

	// Walks the tree over the top bits of one coded byte, leaving the symbols
	// it reaches in walk_out. The walk position carries over to the next byte.
	function automatic void decode_word(input logic [hfw_pkg::BYTE_W-1:0] data,
		input logic [hfw_pkg::NBITS_W-1:0] nb);
		int                        used_bits;
		tree_node_t                here;
		tree_node_t                nxt;
		logic [hfw_pkg::IDX_W-1:0] go;
		used_bits = (nb == 0 || nb > 8) ? 8 : int'(nb);
		for (int k = 0; k < used_bits; k++) begin
			// The leaf flag of the current node is not consulted, only its children.
			here = read_node(walk_at);
			go = data[7 - k] ? here.right : here.left;
			nxt = read_node(go);
			if (nxt.leaf) begin
				walk_out.insert(walk_out.size(), sym_word_t'{nxt.symbol, 1'b0});
				walk_at = '0;
			end else begin
				walk_at = go;
			end
		end
		if (walk_out.size() > 0)
			walk_out[walk_out.size() - 1].last = 1'b1;
	endfunction

	function automatic word_t any_word(input logic act);
		word_t w;
		w.act = act;
		w.idx = hfw_pkg::IDX_W'($urandom_range(0, hfw_pkg::NODES - 1));
		w.leaf = 1'($urandom_range(0, 1));
		w.lc = hfw_pkg::IDX_W'($urandom_range(0, hfw_pkg::NODES - 1));
		w.rc = hfw_pkg::IDX_W'($urandom_range(0, hfw_pkg::NODES - 1));
		w.nsym = hfw_pkg::SYM_W'($urandom);
		w.dbyte = hfw_pkg::BYTE_W'($urandom);
		w.nbits = hfw_pkg::NBITS_W'($urandom_range(0, 15));
		w.typed = 1'b0;
		w.n_exp = 0;
		w.exp_sym = '0;
		return w;
	endfunction

	function automatic word_t ld(input int idx, input int leaf, input int lc, input int rc,
		input int sym);
		word_t w;
		w = any_word(hfw_pkg::ACT_LOAD);
		w.idx = hfw_pkg::IDX_W'(idx);
		w.leaf = 1'(leaf);
		w.lc = hfw_pkg::IDX_W'(lc);
		w.rc = hfw_pkg::IDX_W'(rc);
		w.nsym = hfw_pkg::SYM_W'(sym);
		w.typed = 1'b1;
		return w;
	endfunction

	// A negative count leaves the expectation to the software walk.
	function automatic word_t dc(input int data, input int nb, input int n_exp, input int sym);
		word_t w;
		w = any_word(hfw_pkg::ACT_DECODE);
		w.dbyte = hfw_pkg::BYTE_W'(data);
		w.nbits = hfw_pkg::NBITS_W'(nb);
		w.typed = n_exp >= 0;
		w.n_exp = n_exp < 0 ? 0 : n_exp;
		w.exp_sym = hfw_pkg::SYM_W'(sym);
		return w;
	endfunction

	function automatic logic [hfw_pkg::IDX_W-1:0] pick_known();
		return known_q[$urandom_range(0, known_q.size() - 1)];
	endfunction

	task automatic send_word(input word_t w);
		if (words_sent >= calm_at)
			quiet = 1'b1;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= w.act;
		node_index <= w.idx;
		node_leaf <= w.leaf;
		left_child <= w.lc;
		right_child <= w.rc;
		node_symbol <= w.nsym;
		data_byte <= w.dbyte;
		bit_count <= w.nbits;
		tag_typed <= w.typed;
		tag_n <= w.n_exp;
		tag_sym <= w.exp_sym;
		if (w.act == hfw_pkg::ACT_LOAD && !known[w.idx]) begin
			known[w.idx] = 1'b1;
			known_q.insert(known_q.size(), w.idx);
		end
		words_sent++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	always @(posedge clk) begin : scoreboard
		sym_word_t e;
		if (out_valid === 1'b1 && !out_stall) begin
			if (pending_syms.size() == 0) begin
				$error("symbol: expected none, got %0h", symbol);
				errors++;
			end else begin
				e = pending_syms.pop_front();
				if (symbol !== e.symbol) begin
					$error("symbol: expected %0h, got %0h", e.symbol, symbol);
					errors++;
				end
				if (last_of_byte !== e.last) begin
					$error("last_of_byte: expected %0b, got %0b", e.last, last_of_byte);
					errors++;
				end
			end
		end
		if (in_valid && in_stall === 1'b0) begin
			words_in++;
			if (action == hfw_pkg::ACT_LOAD) begin
				if (int'(node_index) < hfw_pkg::NODES)
					code_tree[node_index] = {node_leaf, left_child, right_child, node_symbol};
			end else begin
				walk_out.delete();
				decode_word(data_byte, bit_count);
				if (tag_typed) begin
					walk_out.delete();
					for (int k = 0; k < tag_n; k++)
						walk_out.insert(walk_out.size(),
							sym_word_t'{tag_sym, 1'(k == tag_n - 1)});
				end
				for (int k = 0; k < walk_out.size(); k++)
					pending_syms.insert(pending_syms.size(), walk_out[k]);
			end
		end
	end

	// Output side: short random stalls, plus one long hold-off that backs the
	// decoder up until it stalls its input.
	initial begin : receiver
		bit held_once;
		held_once = 1'b0;
		@(posedge clk);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!held_once && words_in >= 80) begin
				held_once = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		word_t                     plan [$];
		word_t                     w;
		logic [hfw_pkg::IDX_W-1:0] pool [$];
		logic [hfw_pkg::NODES-1:0] taken;
		logic [hfw_pkg::IDX_W-1:0] idx;
		int                        rand_base;
		int                        leaves;
		int                        p;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two-leaf tree first: every coded bit yields a symbol.
		plan.insert(plan.size(), ld(511, 1, 511, 511, 8'hFF));
		plan.insert(plan.size(), ld(1, 1, 1, 1, 8'h00));
		plan.insert(plan.size(), ld(0, 0, 1, 511, 8'hA5));
		plan.insert(plan.size(), dc(8'hFF, 0, 8, 8'hFF));
		plan.insert(plan.size(), dc(8'h00, 8, 8, 8'h00));
		plan.insert(plan.size(), dc(8'hFF, 15, 8, 8'hFF));
		plan.insert(plan.size(), dc(8'h00, 9, 8, 8'h00));
		plan.insert(plan.size(), dc(8'hF0, 4, 4, 8'hFF));
		plan.insert(plan.size(), dc(8'h7F, 1, 1, 8'h00));
		// Deeper tree, so that a byte can end in the middle of a code.
		plan.insert(plan.size(), ld(2, 0, 1, 511, 8'h00));
		plan.insert(plan.size(), ld(3, 0, 2, 511, 8'hFF));
		plan.insert(plan.size(), ld(0, 0, 3, 1, 8'h3C));
		plan.insert(plan.size(), dc(8'h00, 1, 0, 0));
		plan.insert(plan.size(), dc(8'h00, 1, 0, 0));
		plan.insert(plan.size(), dc(8'h80, 1, -1, 0));
		plan.insert(plan.size(), dc(8'h5A, 0, -1, 0));
		// Rewrite the node the walk stands on, then mark the root as a leaf.
		plan.insert(plan.size(), ld(3, 0, 1, 1, 8'h00));
		plan.insert(plan.size(), dc(8'h00, 2, -1, 0));
		plan.insert(plan.size(), ld(0, 1, 1, 511, 8'h77));
		plan.insert(plan.size(), dc(8'h0F, 0, -1, 0));
		plan.insert(plan.size(), dc(8'hC3, 3, -1, 0));
		plan.insert(plan.size(), ld(0, 0, 3, 1, 8'h00));
		plan.insert(plan.size(), dc(8'hFF, 2, -1, 0));
		for (int i = 0; i < plan.size(); i++)
			send_word(plan[i]);

		rand_base = words_sent;
		calm_at = rand_base + RAND_WORDS - CALM_WORDS;
		while (words_sent - rand_base < RAND_WORDS) begin
			// Build a fresh tree bottom up, root at slot 0 written last. Every
			// child points at a slot already written, so no walk reads garbage.
			leaves = $urandom_range(2, 8);
			pool.delete();
			taken = '0;
			for (int n = 0; n < 2 * leaves - 1; n++) begin
				if (n == 2 * leaves - 2) begin
					idx = '0;
				end else begin
					do idx = hfw_pkg::IDX_W'($urandom_range(1, hfw_pkg::NODES - 1));
					while (taken[idx]);
				end
				taken[idx] = 1'b1;
				w = any_word(hfw_pkg::ACT_LOAD);
				w.idx = idx;
				if (n < leaves) begin
					w.leaf = 1'b1;
					w.lc = pick_known();
					w.rc = pick_known();
				end else begin
					w.leaf = 1'b0;
					p = $urandom_range(0, pool.size() - 1);
					w.lc = pool[p];
					pool.delete(p);
					p = $urandom_range(0, pool.size() - 1);
					w.rc = pool[p];
					pool.delete(p);
				end
				pool.insert(pool.size(), idx);
				send_word(w);
			end
			repeat ($urandom_range(6, 20)) begin
				if ($urandom_range(0, 9) == 0) begin
					w = any_word(hfw_pkg::ACT_LOAD);
					w.lc = pick_known();
					w.rc = pick_known();
				end else begin
					w = any_word(hfw_pkg::ACT_DECODE);
					if ($urandom_range(0, 3) != 0)
						w.nbits = $urandom_range(0, 1) ? hfw_pkg::NBITS_W'(8) : '0;
				end
				send_word(w);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_syms.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_syms.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/hfw_pkg.sv
rtl/hfw_node_mem.sv
rtl/hfw_walk_ctl.sv
rtl/huffman_tree_walk_decoder_top.sv
tb/huffman_tree_walk_decoder_top_tb.sv
